>>> rtl/wgm_pkg.sv
// ============================================================================
// wgm_pkg
// Shared types and constants for the wildcard glob matcher: the command kinds,
// the decoded command that runs from front end to back end, and the result.
// ============================================================================
package wgm_pkg;

    // Default pattern capacity in bytes
    localparam int MAX_PATTERN_DEF = 64;

    // Entries in the command queue between front and back end
    localparam int QUEUE_DEPTH = 2;

    // Pattern wildcard bytes
    localparam logic [7:0] GLOB_STAR = 8'h2A;
    localparam logic [7:0] GLOB_ONE  = 8'h3F;

    // Command kind, coded as the input mode field
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEXT   = 2'd2,
        OP_END    = 2'd3
    } op_kind_t;

    // Decoded command: folded byte plus its wildcard class
    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] char_byte;
        logic       is_star;
        logic       is_one;
    } op_t;

    // Match result
    typedef struct packed {
        logic overflow;
        logic matched;
    } result_t;

endpackage

>>> rtl/wgm_front.sv
// ============================================================================
// wgm_front
// Input stage: takes stream beats, folds upper case letters to lower case,
// classifies the byte as star, single wildcard or literal, and holds the
// decoded command in a register until the queue takes it.
// ============================================================================
module wgm_front
    import wgm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] mode,
    input  logic [7:0] char_code,
    output logic       op_valid,
    input  logic       op_ready,
    output op_t        op
);

    logic     valid_reg;
    op_t      op_reg;
    op_t      op_next;
    logic     accept;
    logic [7:0] folded;

    // Case fold: 'A'..'Z' to 'a'..'z'
    always_comb
    begin
        folded = char_code;
        if (char_code >= 8'h41 && char_code <= 8'h5A)
        begin
            folded = char_code + 8'h20;
        end
    end

    // Decode mode into a command kind; the mode field uses the kind coding
    always_comb
    begin
        op_next.char_byte = folded;
        op_next.is_star   = (folded == GLOB_STAR);
        op_next.is_one    = (folded == GLOB_ONE);
        op_next.kind      = op_kind_t'(mode);
    end

    // Stage register: free when empty or when the queue takes it
    assign in_ready = !valid_reg || op_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (op_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= op_next;
        end
    end

    assign op_valid = valid_reg;
    assign op       = op_reg;

endmodule

>>> rtl/wgm_queue.sv
// ============================================================================
// wgm_queue
// Short command queue between front and back end so that each side can
// stall on its own.
// ============================================================================
module wgm_queue
    import wgm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  op_t  push_op,
    output logic pop_valid,
    input  logic pop_ready,
    output op_t  pop_op
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    op_t              entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_op     = entry_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

>>> rtl/wgm_back.sv
// ============================================================================
// wgm_back
// Execution end: pattern cells, live position vector and result register.
// Each text byte updates all live positions at once; the star closure runs
// as a carry chain through one wide add.
// ============================================================================
module wgm_back
    import wgm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    op_valid,
    output logic    op_ready,
    input  op_t     op,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t result
);

    localparam int W     = MAX_PATTERN + 1;
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);

    // Pattern cells: no reset, only cells below the length are used
    logic [7:0]       cell_byte_reg [MAX_PATTERN];
    logic             cell_star_reg [MAX_PATTERN];
    logic             cell_one_reg  [MAX_PATTERN];

    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [W-1:0]     live_reg;
    logic [W-1:0]     live_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             out_valid_reg;
    result_t          out_reg;

    logic             pop;
    logic             full;
    logic             live_at_end;
    logic             act;
    logic             hit;
    logic [W-1:0]     star_vec;
    logic [W-1:0]     stay;
    logic [W-1:0]     adv;
    logic [W-1:0]     seed;
    logic [W-1:0]     gen;
    logic [W-1:0]     carry;
    logic [W-1:0]     closed;
    logic [W-1:0]     append_bit;

    // An end command waits only for room in the result register
    assign op_ready    = (op.kind != OP_END) || !out_valid_reg || res_ready;
    assign pop         = op_valid && op_ready;
    assign full        = (len_reg == LEN_W'(MAX_PATTERN));
    assign live_at_end = live_reg[len_reg];

    // Per-cell compare against the text byte
    always_comb
    begin
        star_vec = '0;
        stay     = '0;
        adv      = '0;
        act      = 1'b0;
        hit      = 1'b0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            act         = (LEN_W'(i) < len_reg);
            hit         = (cell_byte_reg[i] == op.char_byte) || cell_one_reg[i];
            star_vec[i] = act && cell_star_reg[i];
            stay[i]     = live_reg[i] && act && cell_star_reg[i];
            adv[i + 1]  = live_reg[i] && act && !cell_star_reg[i] && hit;
        end
    end

    // Star closure: live runs forward across stars like a carry
    always_comb
    begin
        seed   = (op.kind == OP_TEXT) ? (stay | adv) : W'(1);
        gen    = seed & star_vec;
        carry  = (gen + star_vec) ^ gen ^ star_vec;
        closed = seed | carry;
    end

    // Appending a star at a live end position opens the next position
    always_comb
    begin
        append_bit = '0;
        for (int i = 1; i < W; i++)
        begin
            append_bit[i] = (len_reg == LEN_W'(i - 1)) && op.is_star && live_at_end;
        end
    end

    // Command execution
    always_comb
    begin
        len_next  = len_reg;
        live_next = live_reg;
        ovf_next  = ovf_reg;
        if (pop)
        begin
            unique case (op.kind)
                OP_CLEAR:
                begin
                    len_next  = '0;
                    ovf_next  = 1'b0;
                    live_next = W'(1);
                end
                OP_APPEND:
                begin
                    if (full)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        len_next  = len_reg + 1'b1;
                        live_next = live_reg | append_bit;
                    end
                end
                OP_TEXT:
                begin
                    live_next = closed;
                end
                default:
                begin
                    live_next = closed;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            live_reg <= W'(1);
            ovf_reg  <= 1'b0;
        end
        else
        begin
            len_reg  <= len_next;
            live_reg <= live_next;
            ovf_reg  <= ovf_next;
        end
    end

    // Pattern cell write at the current length
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            if (pop && op.kind == OP_APPEND && !full && len_reg == LEN_W'(i))
            begin
                cell_byte_reg[i] <= op.char_byte;
                cell_star_reg[i] <= op.is_star;
                cell_one_reg[i]  <= op.is_one;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop && op.kind == OP_END)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && op.kind == OP_END)
        begin
            out_reg.matched  <= live_at_end;
            out_reg.overflow <= ovf_reg;
        end
    end

    assign res_valid = out_valid_reg;
    assign result    = out_reg;

    // Checks
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_PATTERN))
        else $error("pattern length beyond capacity");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> full)
        else $error("overflow set with room left in pattern");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        pop && op.kind == OP_CLEAR |=> live_reg == W'(1) && len_reg == '0)
        else $error("clear did not restore empty pattern");

    a_end_room: assert property (@(posedge clk) disable iff (!rst_n)
        pop && op.kind == OP_END |-> !out_valid_reg || res_ready)
        else $error("end of text taken while result register blocked");

    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        pop && op.kind == OP_END |=> out_valid_reg)
        else $error("end of text gave no result");

endmodule

>>> rtl/wildcard_glob_matcher.sv
// Path: an end-of-text beat passes the input register, a queue entry and the result
// register, in that order, before m_tvalid rises.
// Throughput: one beat per cycle unless a result waits on m_tready; each text byte
// updates every live position at once, the star closure being one (MAX_PATTERN+1)-bit add.
// Reset (async, rst_n low): empty pattern, only position 0 live, overflow clear,
// no result pending; pattern cells are not cleared and need no clearing pass.
// ============================================================================
// wildcard_glob_matcher
// Case-insensitive glob matcher for '*' and '?' with a decoupled front end,
// command queue and bit-parallel execution back end.
// ============================================================================
module wildcard_glob_matcher
    import wgm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic [1:0] s_tuser,   // [1:0] mode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] matched, [1] overflow, [7:2] zero
);

    logic    front_valid;
    logic    front_ready;
    op_t     front_op;
    logic    queue_valid;
    logic    queue_ready;
    op_t     queue_op;
    result_t result;

    wgm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .mode      (s_tuser),
        .char_code (s_tdata),
        .op_valid  (front_valid),
        .op_ready  (front_ready),
        .op        (front_op)
    );

    wgm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_op    (front_op),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_op     (queue_op)
    );

    wgm_back #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_valid  (queue_valid),
        .op_ready  (queue_ready),
        .op        (queue_op),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .result    (result)
    );

    // Result beat packing
    assign m_tdata = {6'b0, result.overflow, result.matched};

endmodule
